### sv/sah_pkg.sv
// Package: shared types, constants and helpers for the SAH split-plane search.
`default_nettype none

package sah_pkg;

  localparam int COORD_BITS            = 16;
  localparam int COST_W                = 48;
  localparam int TC_W                  = 11;
  localparam int AXIS_W                = 2;
  localparam int DEF_MAX_TRIANGLES     = 1024;
  localparam int DEF_PLANE_DIVISIONS   = 100;

  localparam logic [COST_W-1:0] COST_ALL_ONES = {COST_W{1'b1}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one stored triangle
  typedef struct packed {
    coord_t v0x; coord_t v0y; coord_t v0z;
    coord_t v1x; coord_t v1y; coord_t v1z;
    coord_t v2x; coord_t v2y; coord_t v2z;
    coord_t cx;  coord_t cy;  coord_t cz;
  } tri_t;

  typedef struct packed {
    logic done;
    logic cand;
  } cost_sts_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_AXIS,
    ST_DIV,
    ST_PLANE,
    ST_SCAN,
    ST_DRAIN,
    ST_EXT,
    ST_COST,
    ST_NEXT,
    ST_FINISH
  } state_e;

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

endpackage

`default_nettype wire

### sv/sah_if.sv
// Interfaces: triangle input channel and split result channel.
`default_nettype none

interface sah_tri_if;
  import sah_pkg::*;
  logic   valid;
  logic   ready;
  coord_t vertex0_x, vertex0_y, vertex0_z;
  coord_t vertex1_x, vertex1_y, vertex1_z;
  coord_t vertex2_x, vertex2_y, vertex2_z;
  coord_t centroid_x, centroid_y, centroid_z;

  modport source (
    output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
           vertex2_x, vertex2_y, vertex2_z, centroid_x, centroid_y, centroid_z,
    input  ready
  );
  modport sink (
    input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
           vertex2_x, vertex2_y, vertex2_z, centroid_x, centroid_y, centroid_z,
    output ready
  );
endinterface

interface sah_res_if;
  import sah_pkg::*;
  logic              valid;
  logic              ready;
  logic              split_found;
  logic [AXIS_W-1:0] split_axis;
  coord_t            split_pos;
  logic [COST_W-1:0] min_cost;

  modport source (
    output valid, split_found, split_axis, split_pos, min_cost,
    input  ready
  );
  modport sink (
    input  valid, split_found, split_axis, split_pos, min_cost,
    output ready
  );
endinterface

`default_nettype wire

### sv/sah_split_plane_search.sv
// Top level: SAH split-plane search over one node's triangles.
// Usage:
//   tri_i is a valid/ready channel carrying one triangle (three vertices and
//   a centroid, signed Q8.8) per transaction. triangle_count_we_i with
//   triangle_count_i sets the node size (0 acts as 1, large values clamp).
//   Triangles are taken one per cycle while loading. The transaction that
//   completes the node starts the search; tri_i.ready stays low until the
//   search ends, then res_o carries one result transaction.
//   Search order: per axis with distinct centroid extremes, a setup state and
//   a reciprocal division of the centroid range, then for each of the
//   PLANE_DIVISIONS-1 planes one memory read per triangle through the single
//   read port, then 11 steps of the shared multiplier.
//   The result sits in an output register; loading of the next node may
//   start while it waits. If the receiver stalls and the next search ends
//   first, that search waits in its last state until the register frees.
//   Reset: node count 1, nothing loaded, no result pending. The triangle
//   memory is not cleared; only entries of the current node are read.
`default_nettype none

module sah_split_plane_search import sah_pkg::*; #(
  parameter int MAX_TRIANGLES   = DEF_MAX_TRIANGLES,
  parameter int PLANE_DIVISIONS = DEF_PLANE_DIVISIONS
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            triangle_count_we_i,
  input  wire logic [TC_W-1:0] triangle_count_i,
  sah_tri_if.sink              tri_i,
  sah_res_if.source            res_o
);

  localparam int CW     = $clog2(MAX_TRIANGLES + 1);
  localparam int IW     = $clog2(MAX_TRIANGLES);
  localparam int CB     = COORD_BITS;
  localparam int RW     = $clog2(PLANE_DIVISIONS) + 1;
  localparam int PIW    = $clog2(PLANE_DIVISIONS);
  localparam int DCW    = 1;
  localparam int DIV_SH = CB + $clog2(PLANE_DIVISIONS);
  localparam int QPW    = DIV_SH + CB;
  localparam int RCW    = CB + 2;
  localparam logic [RW-1:0]  PD_R      = RW'(PLANE_DIVISIONS);
  localparam logic [CB-1:0]  PD_C      = CB'(PLANE_DIVISIONS);
  localparam logic [PIW-1:0] LAST_PL   = PIW'(PLANE_DIVISIONS - 1);
  localparam logic [DCW-1:0] DIV_LAST  = 1'b1;
  localparam logic [CW-1:0]  MAX_C     = CW'(MAX_TRIANGLES);
  // ceil(2^DIV_SH / PLANE_DIVISIONS): exact quotient for any range below 2^CB
  localparam logic [RCW-1:0] RECIP     = RCW'(((64'd1 << DIV_SH) + 64'(PLANE_DIVISIONS)
                                               - 64'd1) / 64'(PLANE_DIVISIONS));

  state_e state_q, state_d;

  logic [TC_W-1:0]   tc_q;
  logic [CW-1:0]     loaded_q, n_q, target;
  coord_t            clo_q [3];
  coord_t            chi_q [3];
  logic [AXIS_W-1:0] axis_q;
  logic [DCW-1:0]    div_cnt_q;
  logic [CB-1:0]     rng_q;
  logic [QPW-1:0]    quot_w;
  logic [CB-1:0]     qd_w;
  logic [CB-1:0]     dv_q;
  logic [RW-1:0]     rem_q;
  logic [CB-1:0]     q_q;
  logic [RW-1:0]     r_q, r_sum;
  logic [CB-1:0]     q_sum;
  coord_t            pos_q;
  logic [PIW-1:0]    pl_q;
  logic [IW-1:0]     addr_q;
  logic              rd_vld_q;
  tri_t              mem [MAX_TRIANGLES];
  tri_t              rd_q, wr_tri;
  coord_t            blo_q [2][3];
  coord_t            bhi_q [2][3];
  logic [CW-1:0]     bcnt_q [2];
  logic [CB-1:0]     ext_q [2][3];
  logic [COST_W-1:0] low_cost_q, cost;
  logic [AXIS_W-1:0] best_axis_q;
  coord_t            best_pos_q;
  cost_sts_t         csts;
  logic              accept, complete, axis_skip, out_free;
  logic [CB:0]       rng_w;
  coord_t            cen_ax;
  logic              side;
  coord_t            vmin [3];
  coord_t            vmax [3];
  logic              cost_start;

  logic              out_valid_q, out_found_q;
  logic [AXIS_W-1:0] out_axis_q;
  coord_t            out_pos_q;
  logic [COST_W-1:0] out_cost_q;

  // effective node size
  always_comb begin
    if (tc_q == '0) begin
      target = CW'(1);
    end else if (32'(tc_q) > 32'(MAX_TRIANGLES)) begin
      target = MAX_C;
    end else begin
      target = CW'(tc_q);
    end
  end

  assign wr_tri = '{v0x: tri_i.vertex0_x, v0y: tri_i.vertex0_y, v0z: tri_i.vertex0_z,
                    v1x: tri_i.vertex1_x, v1y: tri_i.vertex1_y, v1z: tri_i.vertex1_z,
                    v2x: tri_i.vertex2_x, v2y: tri_i.vertex2_y, v2z: tri_i.vertex2_z,
                    cx: tri_i.centroid_x, cy: tri_i.centroid_y, cz: tri_i.centroid_z};

  assign accept    = tri_i.valid && tri_i.ready;
  assign complete  = (loaded_q + CW'(1)) >= target;
  assign axis_skip = (clo_q[axis_q] == chi_q[axis_q]);
  assign out_free  = !out_valid_q || res_o.ready;
  assign rng_w     = {chi_q[axis_q][CB-1], chi_q[axis_q]}
                   - {clo_q[axis_q][CB-1], clo_q[axis_q]};
  assign quot_w    = QPW'(rng_q) * QPW'(RECIP);
  assign qd_w      = dv_q * PD_C;
  assign r_sum     = r_q + rem_q;
  assign q_sum     = q_q + dv_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:   if (accept && complete) state_d = ST_AXIS;
      ST_AXIS: begin
        if (!axis_skip)            state_d = ST_DIV;
        else if (axis_q == AXIS_Z) state_d = ST_FINISH;
      end
      ST_DIV:    if (div_cnt_q == DIV_LAST) state_d = ST_PLANE;
      ST_PLANE:  state_d = ST_SCAN;
      ST_SCAN:   if (CW'(addr_q) == n_q - CW'(1)) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_EXT;
      ST_EXT:    state_d = ST_COST;
      ST_COST:   if (csts.done) state_d = ST_NEXT;
      ST_NEXT: begin
        if (pl_q != LAST_PL)       state_d = ST_PLANE;
        else if (axis_q == AXIS_Z) state_d = ST_FINISH;
        else                       state_d = ST_AXIS;
      end
      ST_FINISH: if (out_free) state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    tri_i.ready = 1'b0;
    cost_start  = 1'b0;
    unique case (state_q)
      ST_LOAD: tri_i.ready = 1'b1;
      ST_EXT:  cost_start  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      tc_q        <= TC_W'(1);
      loaded_q    <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      axis_q      <= AXIS_X;
      for (int d = 0; d < 3; d++) begin
        clo_q[d] <= COORD_MAXV;
        chi_q[d] <= COORD_MINV;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
      if (triangle_count_we_i) tc_q <= triangle_count_i;
      if (state_q == ST_FINISH && out_free) out_valid_q <= 1'b1;
      else if (res_o.valid && res_o.ready) out_valid_q <= 1'b0;
      if (accept) begin
        loaded_q <= loaded_q + CW'(1);
        if (tri_i.centroid_x < clo_q[0]) clo_q[0] <= tri_i.centroid_x;
        if (tri_i.centroid_x > chi_q[0]) chi_q[0] <= tri_i.centroid_x;
        if (tri_i.centroid_y < clo_q[1]) clo_q[1] <= tri_i.centroid_y;
        if (tri_i.centroid_y > chi_q[1]) chi_q[1] <= tri_i.centroid_y;
        if (tri_i.centroid_z < clo_q[2]) clo_q[2] <= tri_i.centroid_z;
        if (tri_i.centroid_z > chi_q[2]) chi_q[2] <= tri_i.centroid_z;
        if (complete) axis_q <= AXIS_X;
      end
      if ((state_q == ST_AXIS && axis_skip && axis_q != AXIS_Z) ||
          (state_q == ST_NEXT && pl_q == LAST_PL && axis_q != AXIS_Z)) begin
        axis_q <= axis_q + AXIS_W'(1);
      end
      if (state_q == ST_FINISH && out_free) begin
        loaded_q    <= '0;
        for (int d = 0; d < 3; d++) begin
          clo_q[d] <= COORD_MAXV;
          chi_q[d] <= COORD_MINV;
        end
      end
    end
  end

  // triangle memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept) mem[loaded_q[IW-1:0]] <= wr_tri;
    rd_q <= mem[addr_q];
  end

  // per-triangle box update for the side it falls on
  always_comb begin
    case (axis_q)
      AXIS_Y:  cen_ax = rd_q.cy;
      AXIS_Z:  cen_ax = rd_q.cz;
      default: cen_ax = rd_q.cx;
    endcase
    side    = !(cen_ax < pos_q);
    vmin[0] = min3(rd_q.v0x, rd_q.v1x, rd_q.v2x);
    vmin[1] = min3(rd_q.v0y, rd_q.v1y, rd_q.v2y);
    vmin[2] = min3(rd_q.v0z, rd_q.v1z, rd_q.v2z);
    vmax[0] = max3(rd_q.v0x, rd_q.v1x, rd_q.v2x);
    vmax[1] = max3(rd_q.v0y, rd_q.v1y, rd_q.v2y);
    vmax[2] = max3(rd_q.v0z, rd_q.v1z, rd_q.v2z);
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept && complete) begin
      n_q         <= loaded_q + CW'(1);
      low_cost_q  <= COST_ALL_ONES;
      best_axis_q <= AXIS_X;
      best_pos_q  <= '0;
    end
    if (state_q == ST_AXIS) begin
      rng_q     <= rng_w[CB-1:0];
      rem_q     <= '0;
      div_cnt_q <= '0;
      q_q       <= '0;
      r_q       <= '0;
      pl_q      <= PIW'(1);
    end
    // range / PD by reciprocal multiply, then the remainder
    if (state_q == ST_DIV) begin
      div_cnt_q <= div_cnt_q + DCW'(1);
      if (div_cnt_q == '0) dv_q  <= quot_w[DIV_SH +: CB];
      else                 rem_q <= RW'(rng_q - qd_w);
    end
    // plane i position: step quotient and remainder by range/PD
    if (state_q == ST_PLANE) begin
      if (r_sum >= PD_R) begin
        r_q   <= r_sum - PD_R;
        q_q   <= q_sum + CB'(1);
        pos_q <= clo_q[axis_q] + coord_t'(q_sum + CB'(1));
      end else begin
        r_q   <= r_sum;
        q_q   <= q_sum;
        pos_q <= clo_q[axis_q] + coord_t'(q_sum);
      end
      addr_q <= '0;
      for (int s = 0; s < 2; s++) begin
        bcnt_q[s] <= '0;
        for (int d = 0; d < 3; d++) begin
          blo_q[s][d] <= COORD_MAXV;
          bhi_q[s][d] <= COORD_MINV;
        end
      end
    end
    if (state_q == ST_SCAN) addr_q <= addr_q + IW'(1);
    if (rd_vld_q) begin
      bcnt_q[side] <= bcnt_q[side] + CW'(1);
      for (int d = 0; d < 3; d++) begin
        if (vmin[d] < blo_q[side][d]) blo_q[side][d] <= vmin[d];
        if (vmax[d] > bhi_q[side][d]) bhi_q[side][d] <= vmax[d];
      end
    end
    // boxes are complete once the last read has been folded in
    if (state_q == ST_EXT) begin
      for (int s = 0; s < 2; s++) begin
        for (int d = 0; d < 3; d++) begin
          ext_q[s][d] <= CB'(bhi_q[s][d] - blo_q[s][d]);
        end
      end
    end
    if (state_q == ST_NEXT) begin
      pl_q <= pl_q + PIW'(1);
      if (csts.cand && (cost < low_cost_q)) begin
        low_cost_q  <= cost;
        best_axis_q <= axis_q;
        best_pos_q  <= pos_q;
      end
    end
    if (state_q == ST_FINISH && out_free) begin
      out_found_q <= (low_cost_q != COST_ALL_ONES);
      out_axis_q  <= best_axis_q;
      out_pos_q   <= best_pos_q;
      out_cost_q  <= low_cost_q;
    end
  end

  sah_cost #(
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_cost (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cost_start),
    .ext_i   (ext_q),
    .cnt_i   (bcnt_q),
    .sts_o   (csts),
    .cost_o  (cost)
  );

  assign res_o.valid       = out_valid_q;
  assign res_o.split_found = out_found_q;
  assign res_o.split_axis  = out_axis_q;
  assign res_o.split_pos   = out_pos_q;
  assign res_o.min_cost    = out_cost_q;

  a_no_split_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.split_found) |->
      (res_o.min_cost == COST_ALL_ONES && res_o.split_pos == '0 &&
       res_o.split_axis == AXIS_X))
    else $error("result without split carries non-default fields");

  a_scan_in_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CW'(addr_q) < n_q))
    else $error("scan address beyond loaded triangles");

  a_cost_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    csts.done |-> (state_q == ST_COST))
    else $error("cost result outside of cost wait");

endmodule

`default_nettype wire

### sv/sah_cost.sv
// Plane cost unit: one shared multiplier stepped over the two sides' areas and counts.
`default_nettype none

module sah_cost import sah_pkg::*; #(
  parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic [COORD_BITS-1:0]                  ext_i [2][3],
  input  wire logic [$clog2(MAX_TRIANGLES+1)-1:0]     cnt_i [2],
  output cost_sts_t                                   sts_o,
  output logic [COST_W-1:0]                           cost_o
);

  localparam int CW  = $clog2(MAX_TRIANGLES + 1);
  localparam int EW  = COORD_BITS;
  localparam int AW  = 2 * EW + 2;
  localparam int BW  = (EW > CW) ? EW : CW;
  localparam int PW  = AW + BW;
  localparam int TW0 = PW + 1;
  localparam int TW  = (TW0 > COST_W) ? TW0 : COST_W + 1;
  localparam logic [3:0] LAST_STEP = 4'd10;

  logic          busy_q;
  logic [3:0]    step_q;
  logic [PW-1:0] prod_q;
  logic [AW-1:0] area_q;
  logic [TW-1:0] total_q, total_sum;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic          done_q, cand_q;
  logic [COST_W-1:0] cost_q;

  // step schedule: per side the edge products x*y, y*z and z*x, then the summed area times the side's count
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      4'd0: begin mul_a = AW'(ext_i[0][0]); mul_b = BW'(ext_i[0][1]); end
      4'd1: begin mul_a = AW'(ext_i[0][1]); mul_b = BW'(ext_i[0][2]); end
      4'd2: begin mul_a = AW'(ext_i[0][2]); mul_b = BW'(ext_i[0][0]); end
      4'd4: begin mul_a = area_q;           mul_b = BW'(cnt_i[0]);    end
      4'd5: begin mul_a = AW'(ext_i[1][0]); mul_b = BW'(ext_i[1][1]); end
      4'd6: begin mul_a = AW'(ext_i[1][1]); mul_b = BW'(ext_i[1][2]); end
      4'd7: begin mul_a = AW'(ext_i[1][2]); mul_b = BW'(ext_i[1][0]); end
      4'd9: begin mul_a = area_q;           mul_b = BW'(cnt_i[1]);    end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign total_sum = total_q + TW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
      case (step_q)
        4'd1, 4'd6: area_q <= AW'(prod_q);
        4'd2, 4'd3, 4'd7, 4'd8: area_q <= area_q + AW'(prod_q);
        4'd5: total_q <= TW'(prod_q);
        default: ;
      endcase
      if (step_q == LAST_STEP) begin
        cost_q <= (total_sum > TW'(COST_ALL_ONES)) ? COST_ALL_ONES
                                                   : total_sum[COST_W-1:0];
        cand_q <= (cnt_i[0] != '0) && (cnt_i[1] != '0) && (total_sum != '0);
      end
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.cand = cand_q;
  assign cost_o     = cost_q;

endmodule

`default_nettype wire
